### rtl/message_segmenter_crc32_macros.svh
// Assertion macros used by the segmenter back end.
// Every check is clocked on aclk and is off while aresetn is low.
`ifndef MESSAGE_SEGMENTER_CRC32_MACROS_SVH
`define MESSAGE_SEGMENTER_CRC32_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define MSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MSC_ASSERT_IMPL(label, ante, cons, msg)

`define MSC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/msc_pkg.sv
package msc_pkg;

    // Default geometry of the segmenter
    localparam int MAX_PACKET_DEF   = 512;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int MAX_MESSAGE_DEF  = 32768;
    localparam int CHANNEL_BITS_DEF = 16;

    // Field widths
    localparam int DATA_W     = 8;
    localparam int LEN_W      = 16;
    localparam int CHAN_OUT_W = 16;
    localparam int IDX_W      = 8;
    localparam int CNT_W      = 8;
    localparam int PB_W       = 10;

    // Stream positions reach the message length plus the trailer
    localparam int POS_W = LEN_W + 1;

    // CRC-32 trailer
    localparam int          CRC_BYTES = 4;
    localparam int          STEP_W    = 3;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;

    // One classified message byte on its way to the back end
    typedef struct packed {
        logic [DATA_W-1:0]     data;
        logic [CHAN_OUT_W-1:0] chan;
        logic [POS_W-1:0]      idx;
        logic [POS_W-1:0]      off;
        logic [POS_W-1:0]      quot;
        logic [POS_W-1:0]      tm1;
        logic                  has_crc;
        logic [31:0]           crc;
    } msc_entry_t;

    // Reflected CRC-32 over one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [DATA_W-1:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < DATA_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/msc_fifo.sv
module msc_fifo
    import msc_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  msc_entry_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output msc_entry_t pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    msc_entry_t    mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/msc_front.sv
module msc_front
    import msc_pkg::*;
#(
    parameter int MAX_PACKET   = MAX_PACKET_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_MESSAGE  = MAX_MESSAGE_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [DATA_W-1:0] s_data_byte,
    input  logic [LEN_W-1:0]  s_message_bytes,
    input  logic              s_first_byte,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              push_valid,
    input  logic              push_ready,
    output msc_entry_t        push_data
);

    localparam int PAYLOAD   = MAX_PACKET - HEADER_BYTES;
    localparam int OFF_W     = (PAYLOAD > 1) ? $clog2(PAYLOAD) : 1;
    localparam int RCP_SHIFT = POS_W + $clog2(PAYLOAD);
    localparam int MULT_W    = RCP_SHIFT + POS_W;
    localparam logic [63:0] RCP =
        ((64'd1 << RCP_SHIFT) + 64'(PAYLOAD) - 64'd1) / 64'(PAYLOAD);

    logic [31:0]             crc_reg, crc_next;
    logic [LEN_W-1:0]        seen_reg, seen_next;
    logic [CHANNEL_BITS-1:0] chan_cnt_reg, chan_cnt_next;
    logic [CHAN_OUT_W-1:0]   msg_chan_reg, msg_chan_next;
    logic [POS_W-1:0]        idx_reg, idx_next;
    logic [OFF_W-1:0]        off_reg, off_next;
    logic                    drop_reg, drop_next;

    logic [LEN_W-1:0]        len_fix;
    logic                    oversize;
    logic                    emit;
    logic                    take;
    logic [LEN_W-1:0]        pos, pos_inc;
    logic [POS_W-1:0]        idx;
    logic [OFF_W-1:0]        off;
    logic                    wrap;
    logic [POS_W-1:0]        idx_adv;
    logic [OFF_W-1:0]        off_adv;
    logic [31:0]             crc_base, crc_new;
    logic [CHAN_OUT_W-1:0]   chan;
    logic [31:0]             chan_ext;
    logic [POS_W-1:0]        tm1;
    logic [MULT_W-1:0]       prod;

    assign s_ready  = push_ready;
    assign take     = s_valid && s_ready;
    assign chan_ext = 32'(chan_cnt_reg);

    // Classify the byte and compute its stream position
    always_comb begin
        len_fix  = (s_message_bytes == '0) ? LEN_W'(1) : s_message_bytes;
        oversize = 32'(len_fix) > 32'(MAX_MESSAGE);
        if (s_first_byte) begin
            emit     = !oversize;
            pos      = '0;
            idx      = '0;
            off      = '0;
            crc_base = CRC_INIT;
            chan     = chan_ext[CHAN_OUT_W-1:0];
        end else begin
            emit     = !drop_reg && (seen_reg != '0) && (seen_reg < len_fix);
            pos      = seen_reg;
            idx      = idx_reg;
            off      = off_reg;
            crc_base = crc_reg;
            chan     = msg_chan_reg;
        end
        crc_new = crc32_byte(crc_base, s_data_byte);
        pos_inc = pos + LEN_W'(1);
        wrap    = off == OFF_W'(PAYLOAD - 1);
        off_adv = wrap ? '0 : off + OFF_W'(1);
        idx_adv = wrap ? idx + POS_W'(1) : idx;
        // Packet count minus one: (length + 3) / payload by reciprocal
        tm1     = POS_W'(len_fix) + POS_W'(3);
        prod    = MULT_W'(tm1) * MULT_W'(RCP);
    end

    // Hand the classified byte to the queue
    always_comb begin
        push_valid        = take && emit;
        push_data.data    = s_data_byte;
        push_data.chan    = chan;
        push_data.idx     = idx;
        push_data.off     = POS_W'(off);
        push_data.quot    = prod[RCP_SHIFT +: POS_W];
        push_data.tm1     = tm1;
        push_data.has_crc = pos_inc == len_fix;
        push_data.crc     = ~crc_new;
    end

    // Update the message state
    always_comb begin
        crc_next      = crc_reg;
        seen_next     = seen_reg;
        chan_cnt_next = chan_cnt_reg;
        msg_chan_next = msg_chan_reg;
        idx_next      = idx_reg;
        off_next      = off_reg;
        drop_next     = drop_reg;
        if (take) begin
            if (s_first_byte) begin
                drop_next = oversize;
                if (oversize) begin
                    seen_next = '0;
                    crc_next  = CRC_INIT;
                    idx_next  = '0;
                    off_next  = '0;
                end else begin
                    seen_next     = pos_inc;
                    crc_next      = crc_new;
                    idx_next      = idx_adv;
                    off_next      = off_adv;
                    chan_cnt_next = chan_cnt_reg + CHANNEL_BITS'(1);
                    msg_chan_next = chan;
                end
            end else if (emit) begin
                seen_next = pos_inc;
                crc_next  = crc_new;
                idx_next  = idx_adv;
                off_next  = off_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= CRC_INIT;
            seen_reg     <= '0;
            chan_cnt_reg <= '0;
            idx_reg      <= '0;
            off_reg      <= '0;
            drop_reg     <= 1'b0;
        end else begin
            crc_reg      <= crc_next;
            seen_reg     <= seen_next;
            chan_cnt_reg <= chan_cnt_next;
            idx_reg      <= idx_next;
            off_reg      <= off_next;
            drop_reg     <= drop_next;
        end
    end

    // Hold the open message's channel
    always_ff @(posedge aclk) begin
        msg_chan_reg <= msg_chan_next;
    end

endmodule

### rtl/msc_back.sv
`include "message_segmenter_crc32_macros.svh"

module msc_back
    import msc_pkg::*;
#(
    parameter int MAX_PACKET   = MAX_PACKET_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  msc_entry_t            pop_data,
    output logic [DATA_W-1:0]     m_out_byte,
    output logic [CHAN_OUT_W-1:0] m_channel,
    output logic [IDX_W-1:0]      m_packet_index,
    output logic [CNT_W-1:0]      m_packet_count,
    output logic [PB_W-1:0]       m_packet_bytes,
    output logic                  m_is_checksum,
    output logic                  m_packet_end,
    output logic                  m_last_of_run,
    output logic                  m_valid,
    input  logic                  m_ready
);

    localparam int PAYLOAD = MAX_PACKET - HEADER_BYTES;
    localparam int OFF_W   = (PAYLOAD > 1) ? $clog2(PAYLOAD) : 1;
    localparam int QP_W    = 2 * POS_W;
    localparam int SIZE_W  = $clog2(MAX_PACKET + 1);

    // Current entry
    logic                  cur_valid_reg, cur_valid_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DATA_W-1:0]     cur_data_reg, cur_data_next;
    logic [CHAN_OUT_W-1:0] cur_chan_reg, cur_chan_next;
    logic [POS_W-1:0]      cur_idx_reg, cur_idx_next;
    logic [OFF_W-1:0]      cur_off_reg, cur_off_next;
    logic [POS_W-1:0]      cur_quot_reg, cur_quot_next;
    logic [OFF_W-1:0]      cur_rem_reg, cur_rem_next;
    logic                  cur_has_crc_reg, cur_has_crc_next;
    logic [31:0]           cur_crc_reg, cur_crc_next;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]     m_out_byte_reg, m_out_byte_next;
    logic [CHAN_OUT_W-1:0] m_channel_reg, m_channel_next;
    logic [IDX_W-1:0]      m_packet_index_reg, m_packet_index_next;
    logic [CNT_W-1:0]      m_packet_count_reg, m_packet_count_next;
    logic [PB_W-1:0]       m_packet_bytes_reg, m_packet_bytes_next;
    logic                  m_is_checksum_reg, m_is_checksum_next;
    logic                  m_packet_end_reg, m_packet_end_next;
    logic                  m_last_of_run_reg, m_last_of_run_next;

    logic                  emit, emit_last, load;
    logic                  trailer, last_step, res_last, off_wrap;
    logic [1:0]            crc_sel;
    logic [QP_W-1:0]       qp;
    logic [POS_W-1:0]      rem_full;
    logic [POS_W-1:0]      cnt_full;
    logic [SIZE_W-1:0]     last_size, size_full;
    logic [31:0]           size_ext;

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_out_byte_reg;
    assign m_channel      = m_channel_reg;
    assign m_packet_index = m_packet_index_reg;
    assign m_packet_count = m_packet_count_reg;
    assign m_packet_bytes = m_packet_bytes_reg;
    assign m_is_checksum  = m_is_checksum_reg;
    assign m_packet_end   = m_packet_end_reg;
    assign m_last_of_run  = m_last_of_run_reg;

    // Sequence control: one result per cycle while the output slot is free
    always_comb begin
        trailer   = step_reg != '0;
        last_step = step_reg == STEP_W'(CRC_BYTES);
        res_last  = last_step || (!trailer && !cur_has_crc_reg);
        emit      = cur_valid_reg && (!m_valid_reg || m_ready);
        emit_last = emit && res_last;
        pop_ready = !cur_valid_reg || emit_last;
        load      = pop_valid && pop_ready;
        off_wrap  = cur_off_reg == OFF_W'(PAYLOAD - 1);
        crc_sel   = 2'(step_reg - STEP_W'(1));
        // Size of the last packet from the remainder of (length + 3) / payload
        qp        = QP_W'(pop_data.quot) * QP_W'(PAYLOAD);
        rem_full  = pop_data.tm1 - qp[POS_W-1:0];
    end

    // Result fields of the current step
    always_comb begin
        cnt_full  = cur_quot_reg + POS_W'(1);
        last_size = SIZE_W'(cur_rem_reg) + SIZE_W'(1) + SIZE_W'(HEADER_BYTES);
        size_full = (cur_idx_reg < cur_quot_reg) ? SIZE_W'(MAX_PACKET) : last_size;
        size_ext  = 32'(size_full);

        m_out_byte_next     = trailer ? cur_crc_reg[8 * crc_sel +: 8] : cur_data_reg;
        m_channel_next      = cur_chan_reg;
        m_packet_index_next = cur_idx_reg[IDX_W-1:0];
        m_packet_count_next = cnt_full[CNT_W-1:0];
        m_packet_bytes_next = size_ext[PB_W-1:0];
        m_is_checksum_next  = trailer;
        m_packet_end_next   = off_wrap || last_step;
        m_last_of_run_next  = res_last;
        m_valid_next        = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // Advance through the entry, then take the next one from the queue
    always_comb begin
        cur_valid_next   = cur_valid_reg;
        step_next        = step_reg;
        cur_data_next    = cur_data_reg;
        cur_chan_next    = cur_chan_reg;
        cur_idx_next     = cur_idx_reg;
        cur_off_next     = cur_off_reg;
        cur_quot_next    = cur_quot_reg;
        cur_rem_next     = cur_rem_reg;
        cur_has_crc_next = cur_has_crc_reg;
        cur_crc_next     = cur_crc_reg;
        if (emit) begin
            if (res_last) begin
                cur_valid_next = 1'b0;
            end else begin
                step_next    = step_reg + STEP_W'(1);
                cur_off_next = off_wrap ? '0 : cur_off_reg + OFF_W'(1);
                cur_idx_next = off_wrap ? cur_idx_reg + POS_W'(1) : cur_idx_reg;
            end
        end
        if (load) begin
            cur_valid_next   = 1'b1;
            step_next        = '0;
            cur_data_next    = pop_data.data;
            cur_chan_next    = pop_data.chan;
            cur_idx_next     = pop_data.idx;
            cur_off_next     = pop_data.off[OFF_W-1:0];
            cur_quot_next    = pop_data.quot;
            cur_rem_next     = rem_full[OFF_W-1:0];
            cur_has_crc_next = pop_data.has_crc;
            cur_crc_next     = pop_data.crc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Hold payload of the current entry
    always_ff @(posedge aclk) begin
        cur_data_reg    <= cur_data_next;
        cur_chan_reg    <= cur_chan_next;
        cur_idx_reg     <= cur_idx_next;
        cur_off_reg     <= cur_off_next;
        cur_quot_reg    <= cur_quot_next;
        cur_rem_reg     <= cur_rem_next;
        cur_has_crc_reg <= cur_has_crc_next;
        cur_crc_reg     <= cur_crc_next;
    end

    // Capture a result into the output register
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_out_byte_reg     <= m_out_byte_next;
            m_channel_reg      <= m_channel_next;
            m_packet_index_reg <= m_packet_index_next;
            m_packet_count_reg <= m_packet_count_next;
            m_packet_bytes_reg <= m_packet_bytes_next;
            m_is_checksum_reg  <= m_is_checksum_next;
            m_packet_end_reg   <= m_packet_end_next;
            m_last_of_run_reg  <= m_last_of_run_next;
        end
    end

    `MSC_ASSERT_IMPL(a_step_range, cur_valid_reg, step_reg <= STEP_W'(CRC_BYTES), "step past trailer")
    `MSC_ASSERT_IMPL(a_trailer_needs_crc, cur_valid_reg && trailer, cur_has_crc_reg, "trailer without crc")
    `MSC_ASSERT_NEXT(a_run_continues, emit && !emit_last, cur_valid_reg && trailer, "run cut short")
    `MSC_ASSERT_IMPL(a_trailer_ends_packet, m_valid_reg && m_is_checksum_reg && m_last_of_run_reg, m_packet_end_reg, "last crc byte not packet end")

endmodule

### rtl/message_segmenter_crc32.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_data_byte, s_message_bytes, s_first_byte
// m_        out        m_valid / m_ready  m_out_byte, m_channel, m_packet_index,
//                                         m_packet_count, m_packet_bytes, m_is_checksum,
//                                         m_packet_end, m_last_of_run
//
// One input byte per cycle while the queue has room; the last byte of a message holds the back end
// for five results (the byte and four CRC bytes), which its one-result-per-cycle sequencer emits in turn.
// The first result of an input passes through the queue and the current-entry register to the m_ output register.
// s_ready drops only when the four-entry queue is full; m_ready low holds the output register.
// Reset is synchronous on aresetn low and needs no clearing pass.
module message_segmenter_crc32
    import msc_pkg::*;
#(
    parameter int MAX_PACKET   = MAX_PACKET_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_MESSAGE  = MAX_MESSAGE_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [DATA_W-1:0]     s_data_byte,
    input  logic [LEN_W-1:0]      s_message_bytes,
    input  logic                  s_first_byte,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic [DATA_W-1:0]     m_out_byte,
    output logic [CHAN_OUT_W-1:0] m_channel,
    output logic [IDX_W-1:0]      m_packet_index,
    output logic [CNT_W-1:0]      m_packet_count,
    output logic [PB_W-1:0]       m_packet_bytes,
    output logic                  m_is_checksum,
    output logic                  m_packet_end,
    output logic                  m_last_of_run,
    output logic                  m_valid,
    input  logic                  m_ready
);

    logic       push_valid, push_ready;
    logic       pop_valid, pop_ready;
    msc_entry_t push_data, pop_data;

    // Accept and classify bytes, run the CRC
    msc_front #(
        .MAX_PACKET   (MAX_PACKET),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_MESSAGE  (MAX_MESSAGE),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_data_byte     (s_data_byte),
        .s_message_bytes (s_message_bytes),
        .s_first_byte    (s_first_byte),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    // Decouple front and back
    msc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Emit message bytes and CRC trailers with packet metadata
    msc_back #(
        .MAX_PACKET   (MAX_PACKET),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_data       (pop_data),
        .m_out_byte     (m_out_byte),
        .m_channel      (m_channel),
        .m_packet_index (m_packet_index),
        .m_packet_count (m_packet_count),
        .m_packet_bytes (m_packet_bytes),
        .m_is_checksum  (m_is_checksum),
        .m_packet_end   (m_packet_end),
        .m_last_of_run  (m_last_of_run),
        .m_valid        (m_valid),
        .m_ready        (m_ready)
    );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import msc_pkg::*;

    localparam int PAYLOAD     = MAX_PACKET_DEF - HEADER_BYTES_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 210;
    localparam int TAIL_CYCLES = 12;

    // One result of the segmenter as seen on the m_ channel
    typedef struct packed {
        logic [DATA_W-1:0]     out_byte;
        logic [CHAN_OUT_W-1:0] chan;
        logic [IDX_W-1:0]      idx;
        logic [CNT_W-1:0]      cnt;
        logic [PB_W-1:0]       pbytes;
        logic                  ck;
        logic                  pend;
        logic                  last;
    } seg_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic [DATA_W-1:0]     s_data_byte;
    logic [LEN_W-1:0]      s_message_bytes;
    logic                  s_first_byte;
    logic                  s_valid;
    logic                  s_ready;
    logic [DATA_W-1:0]     m_out_byte;
    logic [CHAN_OUT_W-1:0] m_channel;
    logic [IDX_W-1:0]      m_packet_index;
    logic [CNT_W-1:0]      m_packet_count;
    logic [PB_W-1:0]       m_packet_bytes;
    logic                  m_is_checksum;
    logic                  m_packet_end;
    logic                  m_last_of_run;
    logic                  m_valid;
    logic                  m_ready;

    // Segmenter state as tracked by the testbench
    logic [31:0]     crc_state;
    int unsigned     msg_seen;
    logic [15:0]     next_chan;
    bit              dropping;

    seg_result_t     segment_queue[$];
    int unsigned     emitting_items;
    int unsigned     error_count;
    int unsigned     cycle_count;
    bit              calm;
    int              rx_hold;
    seg_result_t     got;
    seg_result_t     want;

    message_segmenter_crc32 i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_data_byte     (s_data_byte),
        .s_message_bytes (s_message_bytes),
        .s_first_byte    (s_first_byte),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .m_out_byte      (m_out_byte),
        .m_channel       (m_channel),
        .m_packet_index  (m_packet_index),
        .m_packet_count  (m_packet_count),
        .m_packet_bytes  (m_packet_bytes),
        .m_is_checksum   (m_is_checksum),
        .m_packet_end    (m_packet_end),
        .m_last_of_run   (m_last_of_run),
        .m_valid         (m_valid),
        .m_ready         (m_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Reflected CRC-32, one input bit at a time
    function automatic logic [31:0] crc_advance(input logic [31:0] c_in,
                                                input logic [DATA_W-1:0] b);
        logic [31:0] c;
        logic        fb;
        c = c_in;
        for (int k = 0; k < DATA_W; k++) begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // Metadata of the stream byte at position pos of a stream of total bytes
    function automatic seg_result_t stream_byte(input logic [DATA_W-1:0] b,
                                                input logic [15:0] ch,
                                                input int unsigned pos,
                                                input int unsigned total,
                                                input bit ck);
        int unsigned count;
        int unsigned idx;
        int unsigned off;
        int unsigned size;
        seg_result_t r;
        count = (total + PAYLOAD - 1) / PAYLOAD;
        idx   = pos / PAYLOAD;
        off   = pos % PAYLOAD;
        if (idx + 1 < count) size = MAX_PACKET_DEF;
        else size = total - idx * PAYLOAD + HEADER_BYTES_DEF;
        r.out_byte = b;
        r.chan     = ch;
        r.idx      = idx[IDX_W-1:0];
        r.cnt      = count[CNT_W-1:0];
        r.pbytes   = size[PB_W-1:0];
        r.ck       = ck;
        r.pend     = (off + 1 == PAYLOAD) || (pos + 1 == total);
        r.last     = 1'b0;
        return r;
    endfunction

    // Work out the results of one input transfer and queue them
    task automatic segment_byte(input logic [DATA_W-1:0] d, input logic [LEN_W-1:0] len_in,
                                input logic f);
        int unsigned len;
        int unsigned total;
        int unsigned pos;
        logic [31:0] fin;
        logic [15:0] ch;
        seg_result_t r;
        len = (len_in == 0) ? 1 : len_in;
        if (f) begin
            crc_state = CRC_INIT;
            msg_seen  = 0;
            if (len > MAX_MESSAGE_DEF) begin
                dropping = 1'b1;
                return;
            end
            dropping  = 1'b0;
            next_chan = next_chan + 16'd1;
        end else if (dropping || msg_seen == 0 || msg_seen >= len) begin
            return;
        end
        emitting_items++;
        ch        = next_chan - 16'd1;
        total     = len + CRC_BYTES;
        pos       = msg_seen;
        crc_state = crc_advance(crc_state, d);
        msg_seen  = (msg_seen + 1) & 32'hFFFF;
        r = stream_byte(d, ch, pos, total, 1'b0);
        if (pos + 1 == len) begin
            segment_queue.push_back(r);
            fin = ~crc_state;
            for (int i = 0; i < CRC_BYTES; i++) begin
                r = stream_byte(fin[8*i +: 8], ch, len + i, total, 1'b1);
                if (i == CRC_BYTES - 1) r.last = 1'b1;
                segment_queue.push_back(r);
            end
        end else begin
            r.last = 1'b1;
            segment_queue.push_back(r);
        end
    endtask

    // Present one byte, hold it until the transfer, then predict
    task automatic send_item(input logic [DATA_W-1:0] d, input logic [LEN_W-1:0] len,
                             input logic f);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= d;
        s_message_bytes <= len;
        s_first_byte    <= f;
        do @(posedge aclk); while (!s_ready);
        segment_byte(d, len, f);
    endtask

    // Send a complete message of random bytes
    task automatic send_message(input int unsigned len);
        send_item(DATA_W'($urandom_range(0, 255)), len[LEN_W-1:0], 1'b1);
        for (int unsigned i = 1; i < len; i++)
            send_item(DATA_W'($urandom_range(0, 255)), len[LEN_W-1:0], 1'b0);
    endtask

    // Drop valid and wait until every queued result has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (segment_queue.size() != 0) @(posedge aclk);
    endtask

    task automatic test_stray_bytes();
        // Nothing open after reset
        send_item(8'hFF, 16'd5, 1'b0);
        send_item(8'h00, 16'd0, 1'b0);
    endtask

    task automatic test_short_messages();
        send_item(8'h00, 16'd1, 1'b1);
        send_item(8'hFF, 16'd3, 1'b1);
        send_item(8'h00, 16'd3, 1'b0);
        send_item(8'hA5, 16'd3, 1'b0);
        // Message complete, the next byte is stray
        send_item(8'h5A, 16'd3, 1'b0);
    endtask

    task automatic test_zero_length();
        // Zero length counts as one byte; the byte after it is stray
        send_item(8'h3C, 16'd0, 1'b1);
        send_item(8'hC3, 16'd0, 1'b0);
    endtask

    task automatic test_oversize();
        send_item(8'h11, LEN_W'(MAX_MESSAGE_DEF + 1), 1'b1);
        send_item(8'h22, LEN_W'(MAX_MESSAGE_DEF + 1), 1'b0);
        send_item(8'h33, LEN_W'(MAX_MESSAGE_DEF + 1), 1'b0);
        send_item(8'hFF, 16'hFFFF, 1'b1);
        send_item(8'h00, 16'hFFFF, 1'b0);
    endtask

    task automatic test_abandon();
        // Largest legal length, cut short by a new first byte
        send_item(8'h80, LEN_W'(MAX_MESSAGE_DEF), 1'b1);
        send_item(8'h01, LEN_W'(MAX_MESSAGE_DEF), 1'b0);
        send_item(8'hFE, LEN_W'(MAX_MESSAGE_DEF), 1'b0);
        send_item(8'h7F, 16'd2, 1'b1);
        send_item(8'h01, 16'd2, 1'b0);
    endtask

    task automatic test_length_change();
        send_item(8'h10, 16'd5, 1'b1);
        send_item(8'h20, 16'd5, 1'b0);
        // Length at or below the bytes seen: ignored
        send_item(8'h30, 16'd2, 1'b0);
        send_item(8'h40, 16'd4, 1'b0);
        send_item(8'h50, 16'd4, 1'b0);
    endtask

    task automatic test_packet_split();
        // Trailer crosses a packet boundary
        send_message(PAYLOAD - 3);
        // Message byte ends a packet, trailer in the second one
        send_message(PAYLOAD + 2);
    endtask

    task automatic test_random();
        int unsigned goal;
        int unsigned len;
        int unsigned k;
        bit          paused;
        goal   = emitting_items + RANDOM_ITEMS;
        paused = 1'b0;
        while (emitting_items < goal) begin
            if (!paused && emitting_items + RANDOM_ITEMS / 2 >= goal) begin
                drain_results();
                paused = 1'b1;
            end
            if (emitting_items + 40 >= goal) calm = 1'b1;
            case ($urandom_range(0, 19))
                15: begin
                    send_item(DATA_W'($urandom_range(0, 255)),
                              LEN_W'($urandom_range(0, 65535)), 1'b0);
                end
                16: begin
                    len = $urandom_range(MAX_MESSAGE_DEF + 1, 65535);
                    send_item(DATA_W'($urandom_range(0, 255)), len[LEN_W-1:0], 1'b1);
                    repeat ($urandom_range(0, 3))
                        send_item(DATA_W'($urandom_range(0, 255)), len[LEN_W-1:0], 1'b0);
                end
                17: begin
                    // Open a message and leave it unfinished
                    len = $urandom_range(2, MAX_MESSAGE_DEF);
                    k   = $urandom_range(1, (len - 1 < 6) ? len - 1 : 6);
                    send_item(DATA_W'($urandom_range(0, 255)), len[LEN_W-1:0], 1'b1);
                    for (int unsigned i = 1; i < k; i++)
                        send_item(DATA_W'($urandom_range(0, 255)), len[LEN_W-1:0], 1'b0);
                end
                18: begin
                    send_item(DATA_W'($urandom_range(0, 255)),
                              LEN_W'($urandom_range(3, 12)), 1'b1);
                    repeat ($urandom_range(1, 8))
                        send_item(DATA_W'($urandom_range(0, 255)),
                                  LEN_W'($urandom_range(0, 15)), 1'b0);
                end
                19: begin
                    send_item(DATA_W'($urandom_range(0, 255)),
                              LEN_W'($urandom_range(0, 65535)),
                              1'($urandom_range(0, 1)));
                end
                default: begin
                    if ($urandom_range(0, 7) == 0) send_message($urandom_range(17, 80));
                    else send_message($urandom_range(1, 16));
                end
            endcase
        end
    endtask

    // Receiver: stall in random bursts
    initial begin
        m_ready <= 1'b0;
        rx_hold = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) rx_hold--;
            else if (!calm && $urandom_range(0, 9) == 0) rx_hold = $urandom_range(1, 14);
            m_ready <= (rx_hold == 0);
        end
    end

    // Compare each result transfer with the oldest queued result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got = {m_out_byte, m_channel, m_packet_index, m_packet_count, m_packet_bytes,
                   m_is_checksum, m_packet_end, m_last_of_run};
            if (segment_queue.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: byte %h chan %h idx %0d", got.out_byte,
                             got.chan, got.idx);
            end else begin
                want = segment_queue.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"mismatch: byte %h/%h chan %h/%h idx %0d/%0d cnt %0d/%0d ",
                                  "size %0d/%0d ck %b/%b end %b/%b last %b/%b"},
                                 want.out_byte, got.out_byte, want.chan, got.chan,
                                 want.idx, got.idx, want.cnt, got.cnt,
                                 want.pbytes, got.pbytes, want.ck, got.ck,
                                 want.pend, got.pend, want.last, got.last);
                end
            end
        end
    end

    // Hard stop for a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("message_segmenter_crc32 test failed");
            $finish;
        end
    end

    initial begin
        error_count     = 0;
        cycle_count     = 0;
        emitting_items  = 0;
        calm            = 1'b0;
        crc_state       = CRC_INIT;
        msg_seen        = 0;
        next_chan       = 16'd0;
        dropping        = 1'b0;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_data_byte     <= '0;
        s_message_bytes <= '0;
        s_first_byte    <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_stray_bytes();
        test_short_messages();
        test_zero_length();
        test_oversize();
        test_abandon();
        test_length_change();
        test_packet_split();
        test_random();

        // Drain, then watch for stray results
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && segment_queue.size() == 0) begin
            $display("message_segmenter_crc32 test passed");
        end else begin
            $display("message_segmenter_crc32 test failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/msc_pkg.sv
rtl/msc_fifo.sv
rtl/msc_front.sv
rtl/msc_back.sv
rtl/message_segmenter_crc32.sv
tb/sv/tb_top.sv
